>>> design/vha_pkg.sv
// shared types and constants of the versioned handle allocator
// no dependencies

package vha_pkg;

	localparam int SLOT_BITS = 10;
	localparam int MAX_SLOTS = 1 << SLOT_BITS;
	localparam int CNT_BITS = SLOT_BITS + 1;
	localparam int VER_BITS = 12;
	localparam int ALU_W = (VER_BITS > CNT_BITS) ? VER_BITS : CNT_BITS;

	localparam int IN_DATA_W = ((SLOT_BITS + VER_BITS + 7) / 8) * 8;
	localparam int OUT_DATA_W = ((SLOT_BITS + VER_BITS + CNT_BITS + 7) / 8) * 8;

	typedef enum logic [1:0] {
		REQ_CREATE  = 2'd0,
		REQ_HINT    = 2'd1,
		REQ_DESTROY = 2'd2,
		REQ_CLEAR   = 2'd3
	} req_e_t;

	typedef enum logic [2:0] {
		STS_CREATED   = 3'd0,
		STS_DESTROYED = 3'd1,
		STS_STALE     = 3'd2,
		STS_FULL      = 3'd3,
		STS_CLEARED   = 3'd4
	} status_e_t;

	// per-slot record: link to next free slot (or own index when live) and version
	typedef struct packed {
		logic [CNT_BITS-1:0] link;
		logic [VER_BITS-1:0] ver;
	} rec_t;

	typedef struct packed {
		logic                 wr_en;
		logic [SLOT_BITS-1:0] wr_addr;
		rec_t                 wr_data;
		logic                 rd_en;
		logic [SLOT_BITS-1:0] rd_addr;
	} mem_req_t;

endpackage

>>> design/vha_rec_store.sv
// slot record memory: one write port, one read port with registered data
// depends on vha_pkg

module vha_rec_store
	import vha_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output rec_t     rd_data
);

	rec_t mem [MAX_SLOTS];
	rec_t rd_data_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_data_q <= mem[req.rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> design/versioned_handle_allocator.sv
// create from free chain passes decode, plain, pop, live, response; append skips pop;
// destroy passes decode, destroy check, live, response; clear decode, response; a hinted
// create past the table end frees skipped slots in grow, an unlink walks read then check
// throughput: one word at a time, next word taken once the sequencer is back in idle
// reset: asynchronous, clears free head to none, used size and live count to zero
// slot record memory is not cleared; only records below used size are ever read

module versioned_handle_allocator
	import vha_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// s_tdata: entity_index[9:0], entity_version[21:10], zero fill
	input  logic [IN_DATA_W-1:0]  s_tdata,
	// s_tuser: req_type[1:0]
	input  logic [1:0]            s_tuser,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// m_tdata: result_index[9:0], result_version[21:10], live_count[32:22], zero fill
	output logic [OUT_DATA_W-1:0] m_tdata,
	// m_tuser: status[2:0]
	output logic [2:0]            m_tuser
);

	// one-hot sequencer states
	typedef enum logic [11:0] {
		ST_IDLE        = 12'b000000000001,
		ST_DECODE      = 12'b000000000010,
		ST_PLAIN       = 12'b000000000100,
		ST_POP         = 12'b000000001000,
		ST_HINT_CHK    = 12'b000000010000,
		ST_GROW        = 12'b000000100000,
		ST_WALK_RD     = 12'b000001000000,
		ST_WALK_CHK    = 12'b000010000000,
		ST_STAMP       = 12'b000100000000,
		ST_DESTROY_CHK = 12'b001000000000,
		ST_LIVE        = 12'b010000000000,
		ST_RESP        = 12'b100000000000
	} state_t;

	localparam logic [CNT_BITS-1:0] NO_SLOT = CNT_BITS'(MAX_SLOTS);

	state_t               state_q;
	req_e_t               req_q;
	logic [SLOT_BITS-1:0] idx_q;
	logic [VER_BITS-1:0]  ver_q;
	logic [CNT_BITS-1:0]  free_head_q;   // NO_SLOT when the chain is empty
	logic [CNT_BITS-1:0]  used_q;
	logic [CNT_BITS-1:0]  live_q;
	logic [CNT_BITS-1:0]  cur_q;         // grow cursor, or chain walk position
	logic [CNT_BITS-1:0]  steps_q;       // chain walk step bound
	logic [CNT_BITS-1:0]  nxt_q;         // link of the hinted slot, spliced into its predecessor
	logic                 live_dec_q;
	logic [SLOT_BITS-1:0] res_idx_q;
	logic [VER_BITS-1:0]  res_ver_q;
	status_e_t            res_sts_q;
	logic                 m_tvalid_q;
	logic [SLOT_BITS-1:0] m_idx_q;
	logic [VER_BITS-1:0]  m_ver_q;
	logic [CNT_BITS-1:0]  m_live_q;
	status_e_t            m_sts_q;

	mem_req_t             mem_req;
	rec_t                 rd_rec;

	logic [CNT_BITS-1:0]  idx_ext;
	logic                 hint_grow;
	logic                 idx_used;
	logic                 chain_empty;
	logic                 link_hits;
	logic                 destroy_ok;
	logic                 s_acc;
	logic                 out_free;

	// shared increment/decrement unit: counters, grow cursor, walk steps, version bump
	logic [ALU_W-1:0]     alu_in;
	logic                 alu_dec;
	logic [ALU_W-1:0]     alu_out;

	vha_rec_store u_store (
		.clk     (clk),
		.req     (mem_req),
		.rd_data (rd_rec)
	);

	assign idx_ext     = {1'b0, idx_q};
	assign hint_grow   = idx_ext >= used_q;
	assign idx_used    = idx_ext < used_q;
	assign chain_empty = free_head_q >= NO_SLOT;
	assign link_hits   = rd_rec.link == idx_ext;
	assign destroy_ok  = link_hits && (rd_rec.ver == ver_q);
	assign s_tready    = state_q == ST_IDLE;
	assign s_acc       = s_tvalid && s_tready;
	assign out_free    = !m_tvalid_q || m_tready;

	always_comb begin
		alu_in  = '0;
		alu_dec = 1'b0;
		unique case (state_q)
			ST_PLAIN:       alu_in = ALU_W'(used_q);
			ST_GROW:        alu_in = ALU_W'(cur_q);
			ST_WALK_CHK:    alu_in = ALU_W'(steps_q);
			ST_DESTROY_CHK: alu_in = ALU_W'(rd_rec.ver);
			ST_LIVE: begin
				alu_in  = ALU_W'(live_q);
				alu_dec = live_dec_q;
			end
			default: alu_in = '0;
		endcase
		alu_out = alu_dec ? (alu_in - ALU_W'(1)) : (alu_in + ALU_W'(1));
	end

	// record memory accesses issued by the sequencer
	always_comb begin
		mem_req = '0;
		unique case (state_q)
			ST_DECODE: begin
				if ((req_q == REQ_HINT && !hint_grow) || (req_q == REQ_DESTROY && idx_used)) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = idx_q;
				end
			end
			ST_PLAIN: begin
				if (chain_empty) begin
					if (used_q != NO_SLOT) begin
						// append a fresh slot at the table end
						mem_req.wr_en   = 1'b1;
						mem_req.wr_addr = used_q[SLOT_BITS-1:0];
						mem_req.wr_data = '{link: used_q, ver: '0};
					end
				end else begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = free_head_q[SLOT_BITS-1:0];
				end
			end
			ST_POP: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = free_head_q[SLOT_BITS-1:0];
				mem_req.wr_data = '{link: free_head_q, ver: rd_rec.ver};
			end
			ST_GROW: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = cur_q[SLOT_BITS-1:0];
				if (cur_q == idx_ext) begin
					mem_req.wr_data = '{link: idx_ext, ver: ver_q};
				end else begin
					mem_req.wr_data = '{link: free_head_q, ver: '0};
				end
			end
			ST_WALK_RD: begin
				if (cur_q < NO_SLOT) begin
					mem_req.rd_en   = 1'b1;
					mem_req.rd_addr = cur_q[SLOT_BITS-1:0];
				end
			end
			ST_WALK_CHK: begin
				if (link_hits) begin
					// splice the hinted slot out of the chain
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = cur_q[SLOT_BITS-1:0];
					mem_req.wr_data = '{link: nxt_q, ver: rd_rec.ver};
				end
			end
			ST_STAMP: begin
				mem_req.wr_en   = 1'b1;
				mem_req.wr_addr = idx_q;
				mem_req.wr_data = '{link: idx_ext, ver: ver_q};
			end
			ST_DESTROY_CHK: begin
				if (destroy_ok) begin
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = idx_q;
					mem_req.wr_data = '{link: free_head_q, ver: alu_out[VER_BITS-1:0]};
				end
			end
			default: mem_req = '0;
		endcase
	end

	// sequencer and state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			req_q       <= REQ_CREATE;
			idx_q       <= '0;
			ver_q       <= '0;
			free_head_q <= NO_SLOT;
			used_q      <= '0;
			live_q      <= '0;
			cur_q       <= '0;
			steps_q     <= '0;
			nxt_q       <= '0;
			live_dec_q  <= 1'b0;
			res_idx_q   <= '0;
			res_ver_q   <= '0;
			res_sts_q   <= STS_CREATED;
			m_tvalid_q  <= 1'b0;
			m_idx_q     <= '0;
			m_ver_q     <= '0;
			m_live_q    <= '0;
			m_sts_q     <= STS_CREATED;
		end else begin
			// drop the taken word, unless the response step loads the next one
			if (m_tvalid_q && m_tready && state_q != ST_RESP) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						req_q   <= req_e_t'(s_tuser);
						idx_q   <= s_tdata[SLOT_BITS-1:0];
						ver_q   <= s_tdata[SLOT_BITS +: VER_BITS];
						state_q <= ST_DECODE;
					end
				end
				ST_DECODE: begin
					live_dec_q <= 1'b0;
					unique case (req_q)
						REQ_CREATE: state_q <= ST_PLAIN;
						REQ_HINT: begin
							if (hint_grow) begin
								cur_q   <= used_q;
								state_q <= ST_GROW;
							end else begin
								state_q <= ST_HINT_CHK;
							end
						end
						REQ_DESTROY: begin
							if (idx_used) begin
								state_q <= ST_DESTROY_CHK;
							end else begin
								res_idx_q <= idx_q;
								res_ver_q <= ver_q;
								res_sts_q <= STS_STALE;
								state_q   <= ST_RESP;
							end
						end
						REQ_CLEAR: begin
							free_head_q <= NO_SLOT;
							used_q      <= '0;
							live_q      <= '0;
							res_idx_q   <= '0;
							res_ver_q   <= '0;
							res_sts_q   <= STS_CLEARED;
							state_q     <= ST_RESP;
						end
						default: state_q <= ST_RESP;
					endcase
				end
				ST_PLAIN: begin
					if (chain_empty) begin
						if (used_q == NO_SLOT) begin
							res_idx_q <= '0;
							res_ver_q <= '0;
							res_sts_q <= STS_FULL;
							state_q   <= ST_RESP;
						end else begin
							res_idx_q <= used_q[SLOT_BITS-1:0];
							res_ver_q <= '0;
							res_sts_q <= STS_CREATED;
							used_q    <= alu_out[CNT_BITS-1:0];
							state_q   <= ST_LIVE;
						end
					end else begin
						state_q <= ST_POP;
					end
				end
				ST_POP: begin
					res_idx_q   <= free_head_q[SLOT_BITS-1:0];
					res_ver_q   <= rd_rec.ver;
					res_sts_q   <= STS_CREATED;
					free_head_q <= rd_rec.link;
					state_q     <= ST_LIVE;
				end
				ST_HINT_CHK: begin
					priority if (link_hits) begin
						// hinted slot is live: fall back to a plain create
						state_q <= ST_PLAIN;
					end else if (free_head_q == idx_ext) begin
						free_head_q <= rd_rec.link;
						state_q     <= ST_STAMP;
					end else begin
						nxt_q   <= rd_rec.link;
						cur_q   <= free_head_q;
						steps_q <= '0;
						state_q <= ST_WALK_RD;
					end
				end
				ST_GROW: begin
					if (cur_q == idx_ext) begin
						used_q    <= alu_out[CNT_BITS-1:0];
						res_idx_q <= idx_q;
						res_ver_q <= ver_q;
						res_sts_q <= STS_CREATED;
						state_q   <= ST_LIVE;
					end else begin
						free_head_q <= cur_q;
						cur_q       <= alu_out[CNT_BITS-1:0];
					end
				end
				ST_WALK_RD: begin
					if (cur_q < NO_SLOT) begin
						state_q <= ST_WALK_CHK;
					end else begin
						state_q <= ST_STAMP;
					end
				end
				ST_WALK_CHK: begin
					priority if (link_hits) begin
						state_q <= ST_STAMP;
					end else if (steps_q == NO_SLOT) begin
						state_q <= ST_STAMP;
					end else begin
						cur_q   <= rd_rec.link;
						steps_q <= alu_out[CNT_BITS-1:0];
						state_q <= ST_WALK_RD;
					end
				end
				ST_STAMP: begin
					res_idx_q <= idx_q;
					res_ver_q <= ver_q;
					res_sts_q <= STS_CREATED;
					state_q   <= ST_LIVE;
				end
				ST_DESTROY_CHK: begin
					res_idx_q <= idx_q;
					res_ver_q <= ver_q;
					if (destroy_ok) begin
						free_head_q <= idx_ext;
						live_dec_q  <= 1'b1;
						res_sts_q   <= STS_DESTROYED;
						state_q     <= ST_LIVE;
					end else begin
						res_sts_q <= STS_STALE;
						state_q   <= ST_RESP;
					end
				end
				ST_LIVE: begin
					live_q  <= alu_out[CNT_BITS-1:0];
					state_q <= ST_RESP;
				end
				ST_RESP: begin
					// result word waits here until the output register frees up
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_idx_q    <= res_idx_q;
						m_ver_q    <= res_ver_q;
						m_sts_q    <= res_sts_q;
						m_live_q   <= live_q;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_DATA_W'({m_live_q, m_ver_q, m_idx_q});
	assign m_tuser  = m_sts_q;

`ifndef NO_ASSERTIONS
	a_live_le_used: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= used_q)
		else $error("live count exceeds used size");

	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(free_head_q <= NO_SLOT) && (used_q <= NO_SLOT))
		else $error("free head or used size out of range");

	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	a_result_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(state_q == ST_RESP))
		else $error("result word raised outside the response step");
`endif

endmodule
